// ----- src/fixed_id_min_priority_queue_core_macros.svh -----
// Assertion macros used by the queue sequencer (fimpq_ctrl).
// Define NO_ASSERTIONS to compile the design without them.
`ifndef FIXED_ID_MIN_PRIORITY_QUEUE_CORE_MACROS_SVH
`define FIXED_ID_MIN_PRIORITY_QUEUE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// General property, checked at every rising edge outside reset.
`define FIMPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication between two conditions.
`define FIMPQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define FIMPQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define FIMPQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- src/fimpq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fimpq_pkg;

    // Table size and derived widths.
    localparam int MAX_SLOTS = 128;
    localparam int IDX_W     = $clog2(MAX_SLOTS);
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

    // Field widths.
    localparam int ID_W   = 16;
    localparam int PRI_W  = 16;
    localparam int CMD_W  = 2;
    localparam int ST_W   = 3;
    localparam int SLT_W  = 8;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    typedef logic signed [PRI_W-1:0] t_prio;
    typedef logic [ID_W-1:0]         t_id;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_SET    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd2;

    // Status codes.
    localparam logic [ST_W-1:0] ST_SET      = 3'd0;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd1;
    localparam logic [ST_W-1:0] ST_RANGE    = 3'd2;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [ST_W-1:0] ST_REMOVED  = 3'd4;
    localparam logic [ST_W-1:0] ST_PEEKED   = 3'd5;

    // Register indexes, taken from paddr[2].
    localparam logic REG_BASE_ID      = 1'b0;
    localparam logic REG_SLOTS_IN_USE = 1'b1;

    // Register reset values.
    localparam t_id             BASE_ID_RESET = 16'd21301;
    localparam logic [SLT_W-1:0] SLOTS_RESET  = 8'd85;

    // Contents of one slot cell.
    typedef struct packed {
        logic  present;
        t_prio prio;
    } t_cell_data;

    // Per-cell control.
    typedef struct packed {
        logic shift;
        logic reload;
        logic reload_present;
        logic clear;
    } t_cell_cmd;

    // Ring control from the sequencer.
    typedef struct packed {
        logic             shift;
        logic             clear;
        logic [IDX_W-1:0] clear_idx;
    } t_ring_ctrl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

endpackage

`default_nettype wire

// ----- src/fimpq_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Request channel.
interface fimpq_in_if;
    logic                             valid;
    logic                             ready;
    logic [fimpq_pkg::CMD_W-1:0]      command;
    logic [fimpq_pkg::ID_W-1:0]       job_id;
    logic signed [fimpq_pkg::PRI_W-1:0] new_priority;

    modport source (output valid, command, job_id, new_priority, input ready);
    modport sink   (input valid, command, job_id, new_priority, output ready);
endinterface

// Result channel.
interface fimpq_out_if;
    logic                        valid;
    logic                        ready;
    logic [fimpq_pkg::ST_W-1:0]  status;
    logic [fimpq_pkg::ID_W-1:0]  result_id;

    modport source (output valid, status, result_id, input ready);
    modport sink   (input valid, status, result_id, output ready);
endinterface

`default_nettype wire

// ----- src/fixed_id_min_priority_queue_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Fixed-id minimum priority queue. The slot table is a ring of MAX_SLOTS cells
// (128) that, while a request runs, rotates one position per cycle past a single
// comparator and write point at its head. Every request, whatever its command,
// takes one full turn of the ring, and the next request is accepted only once the
// sequencer has passed the result of the previous one on. The result sits in an
// output register, so the next request is taken while it waits; a second finished
// result is held in the sequencer until the receiver takes the first. After reset
// and after every register write the table is reloaded, and no request is
// accepted while the reload is pending. Configuration goes through an
// APB-style port with base_id at address 0 and slots_in_use at address 4.
module fixed_id_min_priority_queue_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fimpq_pkg::ADDR_W-1:0]   paddr,
    input  logic [fimpq_pkg::DATA_W-1:0]   pwdata,
    output logic [fimpq_pkg::DATA_W-1:0]   prdata,
    output logic                           pready,
    fimpq_in_if.sink                       i_in,
    fimpq_out_if.source                    o_out
);
    import fimpq_pkg::*;

    t_id              r_base_id;
    logic [SLT_W-1:0] r_slots;
    logic             r_reload;

    logic             w_wr;
    logic [ID_W:0]    w_slots_x;
    logic [ID_W:0]    w_max_x;
    logic [ID_W:0]    w_room;
    logic [ID_W:0]    w_n1;
    logic [ID_W:0]    w_n2;
    logic [CNT_W-1:0] w_live_n;

    t_cell_data w_cell [MAX_SLOTS];
    t_cell_cmd  w_cmd  [MAX_SLOTS];
    t_cell_data w_ret;
    t_ring_ctrl w_ring;

    // Register port; writes complete in the access phase.
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_id <= BASE_ID_RESET;
            r_slots   <= SLOTS_RESET;
            r_reload  <= 1'b1;
        end else begin
            r_reload <= w_wr;
            if (w_wr) begin
                unique case (paddr[2])
                    REG_BASE_ID:      r_base_id <= pwdata[ID_W-1:0];
                    REG_SLOTS_IN_USE: r_slots   <= pwdata[SLT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_BASE_ID:      prdata = DATA_W'(r_base_id);
            REG_SLOTS_IN_USE: prdata = DATA_W'(r_slots);
            default:          prdata = '0;
        endcase
    end

    // Live slot count: limited by the table size and by the top of the id space.
    assign w_slots_x = (ID_W + 1)'(r_slots);
    assign w_max_x   = (ID_W + 1)'(MAX_SLOTS);
    assign w_room    = {1'b1, {ID_W{1'b0}}} - {1'b0, r_base_id};
    assign w_n1      = (w_slots_x < w_max_x) ? w_slots_x : w_max_x;
    assign w_n2      = (w_n1 < w_room) ? w_n1 : w_room;
    assign w_live_n  = w_n2[CNT_W-1:0];

    // Row of slot cells; each takes its right neighbor, the last one takes the head back.
    for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
        assign w_cmd[g].shift          = w_ring.shift;
        assign w_cmd[g].reload         = r_reload;
        assign w_cmd[g].reload_present = (CNT_W'(g) < w_live_n);
        assign w_cmd[g].clear          = w_ring.clear && (w_ring.clear_idx == IDX_W'(g));

        if (g == MAX_SLOTS - 1) begin : g_last
            fimpq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (w_cmd[g]),
                .i_next  (w_ret),
                .o_data  (w_cell[g])
            );
        end else begin : g_mid
            fimpq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (w_cmd[g]),
                .i_next  (w_cell[g+1]),
                .o_data  (w_cell[g])
            );
        end
    end

    // Sequencer with the head comparator and the result register.
    fimpq_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .o_out         (o_out),
        .i_reload_busy (r_reload),
        .i_base_id     (r_base_id),
        .i_live_n      (w_live_n),
        .i_head        (w_cell[0]),
        .o_ret         (w_ret),
        .o_ring        (w_ring)
    );

endmodule

`default_nettype wire

// ----- src/fimpq_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fimpq_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fimpq_pkg::t_cell_cmd  i_cmd,
    input  fimpq_pkg::t_cell_data i_next,
    output fimpq_pkg::t_cell_data o_data
);
    import fimpq_pkg::*;

    logic  r_present;
    t_prio r_prio;

    // Presence bit: reload wins over clear, clear over shift.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= 1'b0;
        end else if (i_cmd.reload) begin
            r_present <= i_cmd.reload_present;
        end else if (i_cmd.clear) begin
            r_present <= 1'b0;
        end else if (i_cmd.shift) begin
            r_present <= i_next.present;
        end
    end

    // Priority value, same order of precedence.
    always_ff @(posedge i_clk) begin
        if (i_cmd.reload || i_cmd.clear) begin
            r_prio <= '0;
        end else if (i_cmd.shift) begin
            r_prio <= i_next.prio;
        end
    end

    assign o_data.present = r_present;
    assign o_data.prio    = r_prio;

endmodule

`default_nettype wire

// ----- src/fimpq_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "fixed_id_min_priority_queue_core_macros.svh"

module fimpq_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    fimpq_in_if.sink                     i_in,
    fimpq_out_if.source                  o_out,
    input  logic                         i_reload_busy,
    input  fimpq_pkg::t_id               i_base_id,
    input  logic [fimpq_pkg::CNT_W-1:0]  i_live_n,
    input  fimpq_pkg::t_cell_data        i_head,
    output fimpq_pkg::t_cell_data        o_ret,
    output fimpq_pkg::t_ring_ctrl        o_ring
);
    import fimpq_pkg::*;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_step;
    logic [CMD_W-1:0] r_cmd;
    logic [IDX_W-1:0] r_k;
    logic             r_in_range;
    t_prio            r_prio;
    logic             r_found;
    logic [IDX_W-1:0] r_best_idx;
    t_prio            r_best_prio;
    logic             r_hit;
    logic             r_out_valid;
    logic [ST_W-1:0]  r_out_status;
    t_id              r_out_id;

    logic             w_accept;
    logic [ID_W:0]    w_diff;
    logic             w_in_range;
    logic             w_last;
    logic             w_better;
    logic             w_set_hit;
    logic             w_push;
    logic [ST_W-1:0]  w_status;
    t_id              w_rid;

    assign w_accept = i_in.valid && i_in.ready;

    // Range check of the requested id against the live slot count.
    assign w_diff     = {1'b0, i_in.job_id} - {1'b0, i_base_id};
    assign w_in_range = (i_in.job_id >= i_base_id) && (w_diff < (ID_W + 1)'(i_live_n));

    assign w_last = (r_step == IDX_W'(MAX_SLOTS - 1));

    // Comparator at the head of the ring; strict less keeps the lowest id on a tie.
    assign w_better  = i_head.present && (!r_found || ($signed(i_head.prio) < $signed(r_best_prio)));
    assign w_set_hit = (r_cmd == CMD_SET) && r_in_range && (r_k == r_step) && i_head.present;

    assign w_push = (r_state == S_FIN) && (!r_out_valid || o_out.ready);

    // Result of the finished request.
    always_comb begin
        w_status = ST_RANGE;
        w_rid    = '0;
        case (r_cmd) inside
            CMD_SET: begin
                if (!r_in_range) begin
                    w_status = ST_RANGE;
                end else if (r_hit) begin
                    w_status = ST_SET;
                end else begin
                    w_status = ST_NOTFOUND;
                end
            end
            CMD_REMOVE, CMD_PEEK: begin
                if (!r_found) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_status = (r_cmd == CMD_REMOVE) ? ST_REMOVED : ST_PEEKED;
                    w_rid    = i_base_id + ID_W'(r_best_idx);
                end
            end
            default: begin
                w_status = ST_RANGE;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (w_last) n_state = S_FIN;
            end
            S_FIN: begin
                if (w_push) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        i_in.ready       = (r_state == S_IDLE) && !i_reload_busy;
        o_ring.shift     = (r_state == S_SCAN);
        o_ring.clear     = w_push && (r_cmd == CMD_REMOVE) && r_found;
        o_ring.clear_idx = r_best_idx;
        o_ret            = i_head;
        if (w_set_hit) o_ret.prio = r_prio;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_found     <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_step  <= '0;
                r_found <= 1'b0;
                r_hit   <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_step <= w_last ? '0 : r_step + 1'b1;
                if (w_better)  r_found <= 1'b1;
                if (w_set_hit) r_hit   <= 1'b1;
            end
            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request, best-candidate and result payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd      <= i_in.command;
            r_k        <= w_diff[IDX_W-1:0];
            r_in_range <= w_in_range;
            r_prio     <= i_in.new_priority;
        end
        if ((r_state == S_SCAN) && w_better) begin
            r_best_idx  <= r_step;
            r_best_prio <= i_head.prio;
        end
        if (w_push) begin
            r_out_status <= w_status;
            r_out_id     <= w_rid;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.status    = r_out_status;
    assign o_out.result_id = r_out_id;

    // One full turn of the ring per request, ending aligned.
    `FIMPQ_ASSERT(a_scan_len, i_clk, i_rst_n, (r_state == S_SCAN && w_last) |=> (r_state == S_FIN), "scan did not end after one full turn")
    `FIMPQ_ASSERT_IMPLY(a_aligned, i_clk, i_rst_n, r_state == S_FIN, r_step == '0, "ring not aligned when finishing")
    `FIMPQ_ASSERT(a_push_src, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == S_FIN), "result loaded outside finish state")
    `FIMPQ_ASSERT_IMPLY(a_hit_range, i_clk, i_rst_n, r_hit, r_in_range, "priority written for an id out of range")

endmodule

`default_nettype wire

// ----- bench/fixed_id_min_priority_queue_core_tb.sv -----
`timescale 1ns / 1ps

module fixed_id_min_priority_queue_core_tb;
    import fimpq_pkg::*;

    // Command code that the block does not define.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Long receiver hold-off, well past two ring turns so the input stalls.
    localparam int HOLD_CYCLES   = 800;
    localparam int PHASE_ITEMS   = 80;
    localparam int ERR_SHOW_MAX  = 10;

    typedef struct packed {
        logic [ST_W-1:0] status;
        t_id             result_id;
    } queue_result_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [DATA_W-1:0]     pwdata;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    fimpq_in_if  in_if ();
    fimpq_out_if out_if ();

    fixed_id_min_priority_queue_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Shadow copy of the slot table and the registers.
    t_id             cfg_base;
    logic [SLT_W-1:0] cfg_slots;
    t_prio           slot_prio [MAX_SLOTS];
    logic            slot_live [MAX_SLOTS];

    queue_result_t   expected_results [$];
    int              mismatch_count;
    logic            src_idle_on;
    logic            sink_idle_on;
    logic            sink_hold_req;

    // Clock.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Number of ids in range under the current registers.
    function automatic int live_count();
        int n;
        int room;
        n    = int'(cfg_slots);
        room = 65536 - int'(cfg_base);
        if (n > MAX_SLOTS) begin
            n = MAX_SLOTS;
        end
        if (n > room) begin
            n = room;
        end
        return n;
    endfunction

    // Reload the shadow table after reset or a register write.
    function automatic void reload_shadow();
        int n;
        n = live_count();
        for (int k = 0; k < MAX_SLOTS; k++) begin
            slot_prio[k] = '0;
            slot_live[k] = (k < n);
        end
    endfunction

    // Apply one request to the shadow table and return the result it causes.
    function automatic queue_result_t predict_queue(input logic [CMD_W-1:0] cmd,
                                                    input t_id id, input t_prio pri);
        queue_result_t r;
        int            n;
        int            k;
        int            best;
        r.status    = ST_RANGE;
        r.result_id = '0;
        case (cmd)
            CMD_SET: begin
                n = live_count();
                k = int'(id) - int'(cfg_base);
                if (k >= 0 && k < n) begin
                    if (slot_live[k]) begin
                        slot_prio[k] = pri;
                        r.status     = ST_SET;
                    end else begin
                        r.status = ST_NOTFOUND;
                    end
                end
            end
            CMD_REMOVE, CMD_PEEK: begin
                best = -1;
                for (k = 0; k < MAX_SLOTS; k++) begin
                    if (slot_live[k] && (best < 0 || slot_prio[k] < slot_prio[best])) begin
                        best = k;
                    end
                end
                if (best < 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.result_id = cfg_base + t_id'(best);
                    if (cmd == CMD_REMOVE) begin
                        slot_live[best] = 1'b0;
                        slot_prio[best] = '0;
                        r.status        = ST_REMOVED;
                    end else begin
                        r.status = ST_PEEKED;
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic log_mismatch(input string what, input int exp_val, input int act_val);
        mismatch_count++;
        if (mismatch_count <= ERR_SHOW_MAX) begin
            $display("%0t: mismatch on %s: expected %0d, actual %0d",
                     $realtime, what, exp_val, act_val);
        end
    endtask

    // Compare every accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        queue_result_t want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_results.size() == 0) begin
                log_mismatch("unexpected result status", -1, int'(out_if.status));
            end else begin
                want = expected_results.pop_front();
                if (out_if.status !== want.status) begin
                    log_mismatch("status", int'(want.status), int'(out_if.status));
                end
                if (out_if.result_id !== want.result_id) begin
                    log_mismatch("result_id", int'(want.result_id), int'(out_if.result_id));
                end
            end
        end
    end

    // Result ready: random bursts of stall, plus one long hold-off on request.
    initial begin : result_sink
        int span;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                out_if.ready <= 1'b0;
                for (span = 1; span < HOLD_CYCLES; span++) begin
                    @(negedge i_clk);
                end
            end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
                out_if.ready <= 1'b0;
                span = $urandom_range(1, 7);
                repeat (span - 1) @(negedge i_clk);
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Offer one request and record its expected result once accepted.
    task automatic send_request(input logic [CMD_W-1:0] cmd, input t_id id,
                                input t_prio pri);
        int gap;
        gap = (src_idle_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.command      <= cmd;
        in_if.job_id       <= id;
        in_if.new_priority <= pri;
        do begin
            @(posedge i_clk);
        end while (!in_if.ready);
        expected_results.push_back(predict_queue(cmd, id, pri));
    endtask

    // Stop offering and wait until every expected result has arrived.
    task automatic wait_all_results();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Write one register with junk in the unused bits, then read it back.
    task automatic write_register(input logic idx, input int unsigned value);
        logic [DATA_W-1:0] data;
        logic [DATA_W-1:0] want;
        wait_all_results();
        data = (idx == REG_BASE_ID) ? (($urandom() & 32'hFFFF_0000) | (value & 32'hFFFF))
                                    : (($urandom() & 32'hFFFF_FF00) | (value & 32'hFF));
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        if (idx == REG_BASE_ID) begin
            cfg_base = data[ID_W-1:0];
        end else begin
            cfg_slots = data[SLT_W-1:0];
        end
        reload_shadow();
        want = (idx == REG_BASE_ID) ? DATA_W'(cfg_base) : DATA_W'(cfg_slots);
        // Read back through the same port.
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        if (prdata !== want) begin
            log_mismatch("register read", int'(want), int'(prdata));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure_table(input int unsigned base, input int unsigned slots);
        write_register(REG_BASE_ID, base);
        write_register(REG_SLOTS_IN_USE, slots);
    endtask

    // Priorities biased toward the extremes and toward ties.
    function automatic t_prio random_priority();
        case ($urandom_range(0, 3))
            0: return t_prio'(int'($urandom_range(0, 8)) - 4);
            1: begin
                case ($urandom_range(0, 3))
                    0:       return 16'sh8000;
                    1:       return 16'sh7FFF;
                    2:       return 16'sh0000;
                    default: return 16'shFFFF;
                endcase
            end
            default: return t_prio'($urandom());
        endcase
    endfunction

    // Mostly well-formed requests on ids in range, with some noise.
    task automatic random_request();
        int  n;
        int  pick;
        t_id id;
        n    = live_count();
        pick = $urandom_range(0, 99);
        id   = (n > 0) ? cfg_base + t_id'($urandom_range(0, n - 1)) : t_id'($urandom());
        if (pick < 50) begin
            send_request(CMD_SET, id, random_priority());
        end else if (pick < 68) begin
            send_request(CMD_REMOVE, t_id'($urandom()), t_prio'($urandom()));
        end else if (pick < 85) begin
            send_request(CMD_PEEK, t_id'($urandom()), t_prio'($urandom()));
        end else if (pick < 95) begin
            send_request(CMD_SET, t_id'($urandom()), random_priority());
        end else begin
            send_request(CMD_UNUSED, t_id'($urandom()), t_prio'($urandom()));
        end
    endtask

    // Reset table: ties, the priority extremes, range edges, removed slots.
    task automatic test_reset_table();
        send_request(CMD_PEEK, 16'd0, 16'sd0);
        send_request(CMD_SET, 16'd21301, 16'sh7FFF);
        send_request(CMD_SET, 16'd21385, 16'sh8000);
        send_request(CMD_SET, 16'd21386, 16'sd7);
        send_request(CMD_SET, 16'd21300, 16'sd7);
        send_request(CMD_PEEK, 16'hFFFF, 16'shFFFF);
        send_request(CMD_REMOVE, 16'd0, 16'sd0);
        send_request(CMD_SET, 16'd21385, 16'sd3);
        send_request(CMD_UNUSED, 16'd21302, 16'sd1);
        send_request(CMD_SET, 16'd21302, -16'sd1);
        send_request(CMD_REMOVE, 16'd0, 16'sd0);
        send_request(CMD_PEEK, 16'd0, 16'sd0);
    endtask

    // Register extremes: tiny table drained to empty, zero count, top of id space.
    task automatic test_config_extremes();
        configure_table(0, 2);
        send_request(CMD_REMOVE, 16'd0, 16'sd0);
        send_request(CMD_REMOVE, 16'd0, 16'sd0);
        send_request(CMD_REMOVE, 16'd0, 16'sd0);
        send_request(CMD_PEEK, 16'd0, 16'sd0);
        send_request(CMD_SET, 16'd0, 16'sd9);
        send_request(CMD_SET, 16'd2, 16'sd9);
        write_register(REG_SLOTS_IN_USE, 0);
        send_request(CMD_PEEK, 16'd0, 16'sd0);
        send_request(CMD_SET, 16'd0, 16'sd1);
        configure_table(65535, 128);
        send_request(CMD_SET, 16'hFFFF, 16'sh8000);
        send_request(CMD_PEEK, 16'd0, 16'sd0);
        configure_table(65500, 255);
        send_request(CMD_SET, 16'hFFFF, 16'sh7FFF);
        send_request(CMD_SET, 16'd65500, 16'sd1);
        send_request(CMD_REMOVE, 16'd0, 16'sd0);
    endtask

    // Receiver holds off for a long time while requests keep coming.
    task automatic test_result_backpressure();
        wait_all_results();
        sink_hold_req = 1'b1;
        repeat (8) begin
            random_request();
        end
        wait_all_results();
    endtask

    // Random phases under several register settings; the last runs without idling.
    task automatic test_random_traffic();
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0:       configure_table($urandom_range(0, 65535), $urandom_range(1, 128));
                1:       configure_table($urandom_range(65400, 65535), 128);
                2:       configure_table($urandom_range(0, 65535), $urandom_range(1, 6));
                3:       configure_table($urandom_range(0, 65535), $urandom_range(0, 255));
                default: configure_table(21301, 85);
            endcase
            if (phase == 4) begin
                src_idle_on  = 1'b0;
                sink_idle_on = 1'b0;
            end
            repeat (PHASE_ITEMS) begin
                random_request();
            end
        end
        wait_all_results();
    endtask

    // Main sequence.
    initial begin
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        in_if.valid        = 1'b0;
        in_if.command      = CMD_SET;
        in_if.job_id       = '0;
        in_if.new_priority = '0;
        mismatch_count     = 0;
        src_idle_on        = 1'b1;
        sink_idle_on       = 1'b1;
        sink_hold_req      = 1'b0;
        cfg_base           = BASE_ID_RESET;
        cfg_slots          = SLOTS_RESET;
        reload_shadow();
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_table();
        test_config_extremes();
        test_result_backpressure();
        test_random_traffic();

        wait_all_results();
        repeat (2 * (MAX_SLOTS + 2)) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Hang guard.
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
